// File: design/per_key_press_repeat_qualifier_top_assert.svh
// ----------------------------------------------------------------------------
// per-key repeat qualifier assertion macros
// concurrent property wrappers on clk, disabled in rst where noted
// ----------------------------------------------------------------------------
`ifndef PER_KEY_PRESS_REPEAT_QUALIFIER_TOP_ASSERT_SVH
`define PER_KEY_PRESS_REPEAT_QUALIFIER_TOP_ASSERT_SVH

// overlapping implication, off during reset
`define KPRQ_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, off during reset
`define KPRQ_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

// next-cycle implication that also covers reset itself
`define KPRQ_ASSERT_RESET(label, ante, cons, msg) \
  label: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: design/kprq_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kprq_pkg
// shared types and constants of the per-key repeat qualifier
// ----------------------------------------------------------------------------
package kprq_pkg;

  localparam int NUM_KEYS_DEF  = 256;
  localparam int TIME_BITS_DEF = 32;

  localparam int KEY_W     = 8;
  localparam int NOW_W     = 32;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_W     = 16;

  localparam logic [CFG_IDX_W-1:0] REG_TRIGGER_MODE    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_HOLD_TIME       = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_REPEAT_INTERVAL = 2'd2;

  localparam logic [2:0] MODE_PRESS        = 3'd0;
  localparam logic [2:0] MODE_RELEASE      = 3'd1;
  localparam logic [2:0] MODE_HOLD         = 3'd2;
  localparam logic [2:0] MODE_REPEAT       = 3'd3;
  localparam logic [2:0] MODE_DELAY_REPEAT = 3'd4;

  localparam logic [2:0]  MODE_RESET     = MODE_PRESS;
  localparam logic [15:0] HOLD_RESET     = 16'd500;
  localparam logic [15:0] INTERVAL_RESET = 16'd100;

  localparam int OUT_FIFO_DEPTH = 4;
  localparam int OUT_FIFO_PTR_W = 2;
  localparam int OUT_FIFO_CNT_W = 3;

  typedef struct packed {
    logic [2:0]  mode;
    logic [15:0] hold;
    logic [15:0] interval;
  } cfg_t;

endpackage

// File: design/kprq_ifs.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kprq channel interfaces
// valid/ready channels for key samples and fire results
// ----------------------------------------------------------------------------
interface kprq_in_if;
  logic        valid;
  logic        ready;
  logic [7:0]  key_index;
  logic        key_down;
  logic [31:0] now_ms;

  modport source (output valid, output key_index, output key_down, output now_ms,
                  input ready);
  modport sink (input valid, input key_index, input key_down, input now_ms,
                output ready);
endinterface

interface kprq_out_if;
  logic valid;
  logic ready;
  logic fire;

  modport source (output valid, output fire, input ready);
  modport sink (input valid, input fire, output ready);
endinterface

// File: design/kprq_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kprq_ram
// generic single-write, single-read ram with registered read data
// ----------------------------------------------------------------------------
module kprq_ram #(
  parameter int WIDTH = 34,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// File: design/kprq_rule.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kprq_rule
// trigger rule: per-key entry update and fire decision for one sample
// ----------------------------------------------------------------------------
module kprq_rule #(
  parameter int TIME_BITS = 32
) (
  input  kprq_pkg::cfg_t         cfg,
  input  logic                   key_ok,
  input  logic                   down,
  input  logic [TIME_BITS-1:0]   now,
  input  logic [TIME_BITS+1:0]   cur,
  output logic                   fire,
  output logic                   we,
  output logic [TIME_BITS+1:0]   upd
);
  import kprq_pkg::*;

  // entry layout: level, phase, mark
  logic                 cur_level;
  logic                 cur_phase;
  logic [TIME_BITS-1:0] cur_mark;
  logic                 first;
  logic                 phase_eff;
  logic [TIME_BITS-1:0] mark_eff;
  logic [TIME_BITS-1:0] elapsed;
  logic                 hold_hit;
  logic                 rep_hit;
  logic                 mode_known;
  logic                 level_n;
  logic                 phase_n;
  logic [TIME_BITS-1:0] mark_n;

  assign cur_level = cur[TIME_BITS+1];
  assign cur_phase = cur[TIME_BITS];
  assign cur_mark  = cur[TIME_BITS-1:0];

  assign first      = !cur_level;
  assign phase_eff  = first ? 1'b0 : cur_phase;
  assign mark_eff   = first ? now : cur_mark;
  assign elapsed    = now - mark_eff;
  assign hold_hit   = elapsed >= TIME_BITS'(cfg.hold);
  assign rep_hit    = elapsed >= TIME_BITS'(cfg.interval);
  assign mode_known = cfg.mode inside {[MODE_PRESS:MODE_DELAY_REPEAT]};

  always_comb begin
    fire    = 1'b0;
    we      = 1'b0;
    level_n = 1'b0;
    phase_n = 1'b0;
    mark_n  = '0;
    if (key_ok && mode_known) begin
      we = 1'b1;
      if (!down) begin
        // release always clears the key
        fire = (cfg.mode == MODE_RELEASE) && cur_level;
      end else begin
        level_n = 1'b1;
        phase_n = phase_eff;
        mark_n  = mark_eff;
        case (cfg.mode)
          MODE_PRESS: begin
            fire = first;
          end
          MODE_RELEASE: begin
            fire = 1'b0;
          end
          MODE_HOLD: begin
            if (!phase_eff && hold_hit) begin
              phase_n = 1'b1;
              fire    = 1'b1;
            end
          end
          MODE_REPEAT: begin
            if (first) begin
              fire = 1'b1;
            end else if (rep_hit) begin
              mark_n = now;
              fire   = 1'b1;
            end
          end
          MODE_DELAY_REPEAT: begin
            if (first) begin
              fire = 1'b1;
            end else if (!phase_eff) begin
              if (hold_hit) begin
                phase_n = 1'b1;
                mark_n  = now;
                fire    = 1'b1;
              end
            end else if (rep_hit) begin
              mark_n = now;
              fire   = 1'b1;
            end
          end
          default: begin
            fire = 1'b0;
          end
        endcase
      end
    end
  end

  assign upd = {level_n, phase_n, mark_n};

endmodule

// File: design/kprq_out_fifo.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kprq_out_fifo
// small result queue that decouples the update stage from the output side
// ----------------------------------------------------------------------------
module kprq_out_fifo (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            push,
  input  logic                            push_fire,
  kprq_out_if.source                      out_ch,
  output logic [kprq_pkg::OUT_FIFO_CNT_W-1:0] level
);
  import kprq_pkg::*;

  logic                      slots [OUT_FIFO_DEPTH];
  logic [OUT_FIFO_PTR_W-1:0] wr_ptr;
  logic [OUT_FIFO_PTR_W-1:0] rd_ptr;
  logic [OUT_FIFO_CNT_W-1:0] count;
  logic                      pop;

  assign pop          = out_ch.valid && out_ch.ready;
  assign out_ch.valid = count != '0;
  assign out_ch.fire  = slots[rd_ptr];
  assign level        = count;

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_fire;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      case ({push, pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

endmodule

// File: design/per_key_press_repeat_qualifier_top.sv
`timescale 1ns / 1ps
// an accepted word is registered in the update stage, then queued for out_ch;
// one word per cycle while in_ch.ready is high; per-key state is a ram read
// at accept, written back in the cycle after, the last write forwarded to the
// next word; reset clears the controls, then a clearing pass zeroes the
// key ram while in_ch.ready stays low; config writes are taken meanwhile
// ----------------------------------------------------------------------------
// per_key_press_repeat_qualifier_top
// per-key typematic qualifier: press, release, hold and auto-repeat triggers
// ----------------------------------------------------------------------------
module per_key_press_repeat_qualifier_top #(
  parameter int NUM_KEYS  = kprq_pkg::NUM_KEYS_DEF,
  parameter int TIME_BITS = kprq_pkg::TIME_BITS_DEF
) (
  input  logic                           clk,
  input  logic                           rst,
  kprq_in_if.sink                        in_ch,
  kprq_out_if.source                     out_ch,
  input  logic                           cfg_we,
  input  logic [kprq_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [kprq_pkg::CFG_W-1:0]     cfg_data
);
  import kprq_pkg::*;

  localparam int ADDR_W  = $clog2(NUM_KEYS);
  localparam int ENTRY_W = TIME_BITS + 2;
  localparam int OCC_W   = OUT_FIFO_CNT_W + 1;

  cfg_t cfg;

  logic              clearing;
  logic [ADDR_W-1:0] clr_addr;

  logic                 accept;
  logic                 s1_valid;
  logic [ADDR_W-1:0]    s1_addr;
  logic                 s1_ok;
  logic                 s1_down;
  logic [TIME_BITS-1:0] s1_now;

  logic               wb_valid;
  logic [ADDR_W-1:0]  wb_addr;
  logic [ENTRY_W-1:0] wb_data;

  logic [ENTRY_W-1:0] rdata;
  logic [ENTRY_W-1:0] cur;
  logic [ENTRY_W-1:0] upd;
  logic               rule_fire;
  logic               rule_we;
  logic               ram_we;
  logic [ADDR_W-1:0]  ram_waddr;
  logic [ENTRY_W-1:0] ram_wdata;
  logic [ADDR_W-1:0]  ram_raddr;

  logic [OUT_FIFO_CNT_W-1:0] fifo_level;
  logic [OCC_W-1:0]          occupancy;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.mode     <= MODE_RESET;
      cfg.hold     <= HOLD_RESET;
      cfg.interval <= INTERVAL_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_TRIGGER_MODE:    cfg.mode     <= cfg_data[2:0];
        REG_HOLD_TIME:       cfg.hold     <= cfg_data;
        REG_REPEAT_INTERVAL: cfg.interval <= cfg_data;
        default:             cfg          <= cfg;
      endcase
    end
  end

  // clearing pass over the key ram after reset
  always_ff @(posedge clk) begin
    if (rst) begin
      clearing <= 1'b1;
      clr_addr <= '0;
    end else if (clearing) begin
      clr_addr <= clr_addr + 1'b1;
      if (clr_addr == ADDR_W'(NUM_KEYS - 1)) begin
        clearing <= 1'b0;
      end
    end
  end

  // words in the update stage plus queued results never exceed the queue depth
  assign occupancy   = OCC_W'(fifo_level) + OCC_W'(s1_valid);
  assign in_ch.ready = !clearing && (occupancy < OCC_W'(OUT_FIFO_DEPTH));
  assign accept      = in_ch.valid && in_ch.ready;
  assign ram_raddr   = ADDR_W'(in_ch.key_index);

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else begin
      s1_valid <= accept;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_addr <= ADDR_W'(in_ch.key_index);
      s1_ok   <= 32'(in_ch.key_index) < NUM_KEYS;
      s1_down <= in_ch.key_down;
      s1_now  <= TIME_BITS'(in_ch.now_ms);
    end
  end

  // the ram read issued with the next word misses this cycle's write
  always_ff @(posedge clk) begin
    if (rst) begin
      wb_valid <= 1'b0;
    end else begin
      wb_valid <= s1_valid && rule_we;
    end
  end

  always_ff @(posedge clk) begin
    wb_addr <= s1_addr;
    wb_data <= upd;
  end

  assign cur = (wb_valid && (wb_addr == s1_addr)) ? wb_data : rdata;

  kprq_rule #(
    .TIME_BITS (TIME_BITS)
  ) u_rule (
    .cfg    (cfg),
    .key_ok (s1_ok),
    .down   (s1_down),
    .now    (s1_now),
    .cur    (cur),
    .fire   (rule_fire),
    .we     (rule_we),
    .upd    (upd)
  );

  assign ram_we    = clearing || (s1_valid && rule_we);
  assign ram_waddr = clearing ? clr_addr : s1_addr;
  assign ram_wdata = clearing ? '0 : upd;

  kprq_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (NUM_KEYS)
  ) u_key_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (rdata)
  );

  kprq_out_fifo u_out_fifo (
    .clk       (clk),
    .rst       (rst),
    .push      (s1_valid),
    .push_fire (rule_fire),
    .out_ch    (out_ch),
    .level     (fifo_level)
  );

endmodule

// File: design/kprq_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kprq_checker
// port-level checks of the per-key repeat qualifier, bound to the top level
// ----------------------------------------------------------------------------
`include "per_key_press_repeat_qualifier_top_assert.svh"

module kprq_checker (
  input logic clk,
  input logic rst,
  input logic in_valid,
  input logic in_ready,
  input logic out_valid,
  input logic out_ready,
  input logic fire
);

  // ram clearing holds off input right after reset
  `KPRQ_ASSERT_RESET(a_clear_after_reset, rst, !in_ready, "input ready during clear")

  // every accepted word shows up as a result after the update stage and the queue
  `KPRQ_ASSERT_NOW(a_result_follows, in_valid && in_ready, ##2 out_valid, "result missing")

  `KPRQ_ASSERT_NEXT(a_out_valid_holds, out_valid && !out_ready, out_valid, "out valid dropped")

  `KPRQ_ASSERT_NEXT(a_out_fire_holds, out_valid && !out_ready, $stable(fire), "stalled fire moved")

endmodule

bind per_key_press_repeat_qualifier_top kprq_checker u_kprq_checker (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (in_ch.valid),
  .in_ready  (in_ch.ready),
  .out_valid (out_ch.valid),
  .out_ready (out_ch.ready),
  .fire      (out_ch.fire)
);
